// ===== sv/mpgpio_pkg.sv =====
// ----------------------------------------------------------------------------
// mpgpio_pkg
// Shared types, register offsets and the pin count table for the multi-port
// GPIO register block.
// ----------------------------------------------------------------------------
package mpgpio_pkg;

    localparam int NUM_PORTS_DEF = 10;
    localparam int PORT_MAX      = 16;
    localparam int PORT_WIDTH    = 32;
    localparam int DATA_W        = 32;
    localparam int OFS_W         = 10;
    localparam int PORT_IDX_W    = 4;
    localparam int REG_OFS_W     = 6;
    localparam int CNT_W         = 6;

    typedef logic [REG_OFS_W-1:0] reg_ofs_t;

    localparam reg_ofs_t R_DAT = 6'h00;
    localparam reg_ofs_t R_DOE = 6'h04;
    localparam reg_ofs_t R_FS0 = 6'h08;
    localparam reg_ofs_t R_FS1 = 6'h0c;
    localparam reg_ofs_t R_RPU = 6'h30;
    localparam reg_ofs_t R_RPD = 6'h34;
    localparam reg_ofs_t R_DV0 = 6'h38;
    localparam reg_ofs_t R_DV1 = 6'h3c;

    typedef enum logic
    {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    localparam logic [CNT_W-1:0] PIN_COUNTS [PORT_MAX] = '{
        6'd13, 6'd24, 6'd20, 6'd8, 6'd20, 6'd6, 6'd24, 6'd8,
        6'd29, 6'd11, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32
    };

    typedef struct packed
    {
        logic [DATA_W-1:0] pin_levels;
        logic [DATA_W-1:0] write_data;
        logic [OFS_W-1:0]  offset;
        op_t               operation;
    } req_t;

    typedef struct packed
    {
        logic [DATA_W-1:0] pulldown_mask;
        logic [DATA_W-1:0] pullup_mask;
        logic [DATA_W-1:0] drive_enable;
        logic [DATA_W-1:0] drive_value;
        logic [DATA_W-1:0] read_data;
        logic              unmapped;
    } res_t;

    function automatic logic [DATA_W-1:0] pin_mask(input logic [PORT_IDX_W-1:0] port);
        logic [CNT_W-1:0]  n;
        logic [DATA_W-1:0] m;
        n = PIN_COUNTS[port];
        if (n > CNT_W'(PORT_WIDTH))
        begin
            n = CNT_W'(PORT_WIDTH);
        end
        if (n >= CNT_W'(DATA_W))
        begin
            m = '1;
        end
        else
        begin
            m = (DATA_W'(1) << n) - DATA_W'(1);
        end
        return m;
    endfunction

endpackage

// ===== sv/multi_port_gpio_registers.sv =====
// ----------------------------------------------------------------------------
// multi_port_gpio_registers
// Register file of a GPIO block with data, output-enable, pull and drive
// strength registers per port, reporting the addressed port's pin drive.
// ----------------------------------------------------------------------------
// One bus access enters per cycle while s_tready is high; its result word passes
// through the input register, then decode, register file read and update and
// the drive masks in one pass into the result register.
// The block sustains one word per clock whenever the result side is ready.
// Drive fields reflect the port state after the access has taken effect.
// ----------------------------------------------------------------------------
module multi_port_gpio_registers
#(
    parameter int NUM_PORTS = mpgpio_pkg::NUM_PORTS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // offset, write_data, pin_levels
    input  logic         s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // read_data, drive_value, drive_enable,
                                    // pullup_mask, pulldown_mask
    output logic         m_tuser    // unmapped
);
    import mpgpio_pkg::*;

    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    logic              in_valid_reg;
    req_t              in_req_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              out_res_reg;
    res_t              out_res_next;
    logic              advance;

    logic [DATA_W-1:0] dat_reg [NUM_PORTS];
    logic [DATA_W-1:0] doe_reg [NUM_PORTS];
    logic [DATA_W-1:0] rpu_reg [NUM_PORTS];
    logic [DATA_W-1:0] rpd_reg [NUM_PORTS];
    logic [DATA_W-1:0] dv0_reg [NUM_PORTS];
    logic [DATA_W-1:0] dv1_reg [NUM_PORTS];

    logic [PORT_IDX_W-1:0] port;
    reg_ofs_t              reg_ofs;
    logic                  port_ok;
    logic [PIDX_W-1:0]     idx;
    logic                  is_wr;
    logic [DATA_W-1:0]     mask;
    logic [DATA_W-1:0]     dat_cur;
    logic [DATA_W-1:0]     doe_cur;
    logic [DATA_W-1:0]     rpu_cur;
    logic [DATA_W-1:0]     rpd_cur;
    logic [DATA_W-1:0]     dat_new;
    logic [DATA_W-1:0]     doe_new;
    logic [DATA_W-1:0]     rpu_new;
    logic [DATA_W-1:0]     rpd_new;
    logic                  wr_dat;
    logic                  wr_doe;
    logic                  wr_rpu;
    logic                  wr_rpd;
    logic                  wr_dv0;
    logic                  wr_dv1;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg.operation  <= op_t'(s_tuser);
            in_req_reg.offset     <= s_tdata[9:0];
            in_req_reg.write_data <= s_tdata[41:10];
            in_req_reg.pin_levels <= s_tdata[73:42];
        end
    end

    // decode
    assign port    = in_req_reg.offset[OFS_W-1:REG_OFS_W];
    assign reg_ofs = in_req_reg.offset[REG_OFS_W-1:0];
    assign port_ok = {1'b0, port} < (PORT_IDX_W + 1)'(NUM_PORTS);
    assign idx     = port_ok ? port[PIDX_W-1:0] : '0;
    assign is_wr   = (in_req_reg.operation == OP_WRITE);
    assign mask    = pin_mask(port);

    assign dat_cur = dat_reg[idx];
    assign doe_cur = doe_reg[idx];
    assign rpu_cur = rpu_reg[idx];
    assign rpd_cur = rpd_reg[idx];

    always_comb
    begin
        wr_dat       = 1'b0;
        wr_doe       = 1'b0;
        wr_rpu       = 1'b0;
        wr_rpd       = 1'b0;
        wr_dv0       = 1'b0;
        wr_dv1       = 1'b0;
        out_res_next = '0;
        if (!port_ok)
        begin
            out_res_next.unmapped = 1'b1;
        end
        else
        begin
            unique case (reg_ofs) inside
                R_DAT:
                begin
                    wr_dat = is_wr;
                    out_res_next.read_data = (dat_cur & doe_cur)
                        | (in_req_reg.pin_levels & mask & ~doe_cur);
                end
                R_DOE:
                begin
                    wr_doe = is_wr;
                    out_res_next.read_data = doe_cur;
                end
                R_FS0, R_FS1:
                begin
                    out_res_next.read_data = '0;
                end
                R_RPU:
                begin
                    wr_rpu = is_wr;
                    out_res_next.read_data = rpu_cur;
                end
                R_RPD:
                begin
                    wr_rpd = is_wr;
                    out_res_next.read_data = rpd_cur;
                end
                R_DV0:
                begin
                    wr_dv0 = is_wr;
                    out_res_next.read_data = dv0_reg[idx];
                end
                R_DV1:
                begin
                    wr_dv1 = is_wr;
                    out_res_next.read_data = dv1_reg[idx];
                end
                default:
                begin
                    out_res_next.unmapped = 1'b1;
                end
            endcase
        end
        if (is_wr)
        begin
            out_res_next.read_data = '0;
        end

        // drive as seen after this access
        dat_new = wr_dat ? in_req_reg.write_data : dat_cur;
        doe_new = wr_doe ? in_req_reg.write_data : doe_cur;
        rpu_new = wr_rpu ? in_req_reg.write_data : rpu_cur;
        rpd_new = wr_rpd ? in_req_reg.write_data : rpd_cur;
        if (port_ok)
        begin
            out_res_next.drive_value   = dat_new & mask;
            out_res_next.drive_enable  = doe_new & mask;
            out_res_next.pulldown_mask = rpd_new & ~doe_new & mask;
            out_res_next.pullup_mask   = rpu_new & ~rpd_new & ~doe_new & mask;
        end
    end

    // port register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                dat_reg[i] <= '0;
                doe_reg[i] <= '0;
                rpu_reg[i] <= '0;
                rpd_reg[i] <= '0;
                dv0_reg[i] <= '0;
                dv1_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            if (wr_dat)
            begin
                dat_reg[idx] <= in_req_reg.write_data;
            end
            if (wr_doe)
            begin
                doe_reg[idx] <= in_req_reg.write_data;
            end
            if (wr_rpu)
            begin
                rpu_reg[idx] <= in_req_reg.write_data;
            end
            if (wr_rpd)
            begin
                rpd_reg[idx] <= in_req_reg.write_data;
            end
            if (wr_dv0)
            begin
                dv0_reg[idx] <= in_req_reg.write_data;
            end
            if (wr_dv1)
            begin
                dv1_reg[idx] <= in_req_reg.write_data;
            end
        end
    end

    // result register
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.pulldown_mask, out_res_reg.pullup_mask,
                       out_res_reg.drive_enable, out_res_reg.drive_value,
                       out_res_reg.read_data};
    assign m_tuser  = out_res_reg.unmapped;

endmodule
